>>> sv/string_escape_utf8_decoder_assert.svh
// Assertion macros shared by the string escape decoder RTL.
`ifndef STRING_ESCAPE_UTF8_DECODER_ASSERT_SVH
`define STRING_ESCAPE_UTF8_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SEUD_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SEUD_ASSERT(lbl, prop, msg) `SEUD_ASSERT_CLK(lbl, aclk, aresetn, prop, msg)
`else
`define SEUD_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define SEUD_ASSERT(lbl, prop, msg)
`endif

`endif

>>> sv/seud_pkg.sv
// Shared types for the string escape decoder.
package seud_pkg;

    localparam int GrpBytes = 4;

    // Results caused by one input beat; cnt_m1 is the result count minus one.
    typedef struct packed {
        logic [GrpBytes-1:0][7:0] data;
        logic [1:0]               cnt_m1;
        logic                     err;
        logic                     str_end;
    } seud_grp_t;

endpackage

>>> sv/seud_decode.sv
// Escape decoder state and per-byte decode into a group of up to four results.
module seud_decode (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_accept,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output seud_pkg::seud_grp_t grp,
    output logic                grp_valid
);
    import seud_pkg::*;

    localparam logic [2:0] MODE_PLAIN = 3'd0;
    localparam logic [2:0] MODE_ESC   = 3'd1;
    localparam logic [2:0] MODE_HEX   = 3'd2;
    localparam logic [2:0] MODE_RAW   = 3'd3;
    localparam logic [2:0] MODE_DROP  = 3'd4;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_UP_B   = 8'h42;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_UP_N   = 8'h4E;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [7:0] CH_UP_R   = 8'h52;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_UP_T   = 8'h54;
    localparam logic [7:0] CH_LO_X   = 8'h78;
    localparam logic [7:0] CH_UP_X   = 8'h58;
    localparam logic [7:0] CH_LO_U   = 8'h75;
    localparam logic [7:0] CH_UP_U   = 8'h55;

    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_FF  = 8'h0C;
    localparam logic [7:0] CTL_LF  = 8'h0A;
    localparam logic [7:0] CTL_CR  = 8'h0D;
    localparam logic [7:0] CTL_TAB = 8'h09;

    localparam logic [31:0] CP_MAX1 = 32'h0000_007F;
    localparam logic [31:0] CP_MAX2 = 32'h0000_07FF;
    localparam logic [31:0] CP_MAX3 = 32'h0000_FFFF;
    localparam logic [31:0] CP_MAX  = 32'h0010_FFFF;
    localparam logic [7:0]  LEAD2   = 8'hC0;
    localparam logic [7:0]  LEAD3   = 8'hE0;
    localparam logic [7:0]  LEAD4   = 8'hF0;
    localparam logic [7:0]  CONT    = 8'h80;

    logic [2:0]  mode_reg, mode_next;
    logic [3:0]  needed_reg, needed_next;
    logic [3:0]  seen_reg, seen_next;
    logic [31:0] acc_reg, acc_next;
    logic [1:0]  raw_reg, raw_next;

    logic [3:0]  hex_d;
    logic        hex_ok;
    logic [31:0] acc_sh;
    logic [3:0]  seen_inc;
    logic [20:0] cp;
    logic        fail;
    logic        err;
    logic [2:0]  n;
    logic [2:0]  n_m1;
    logic [GrpBytes-1:0][7:0] bytes;

    always_comb begin
        hex_ok = 1'b1;
        hex_d  = 4'd0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
            hex_d = in_byte[3:0];
        end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                     (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
            hex_d = in_byte[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign acc_sh   = {acc_reg[27:0], hex_d};
    assign seen_inc = seen_reg + 4'd1;
    assign cp       = acc_sh[20:0];

    always_comb begin
        mode_next   = mode_reg;
        needed_next = needed_reg;
        seen_next   = seen_reg;
        acc_next    = acc_reg;
        raw_next    = raw_reg;
        fail        = 1'b0;
        err         = 1'b0;
        n           = 3'd0;
        bytes       = '0;

        case (mode_reg)
            MODE_ESC: begin
                mode_next = MODE_PLAIN;
                n         = 3'd1;
                case (in_byte)
                    CH_BSLASH, CH_APOS, CH_QUOTE: bytes[0] = in_byte;
                    CH_LO_B, CH_UP_B:             bytes[0] = CTL_BS;
                    CH_LO_F, CH_UP_F:             bytes[0] = CTL_FF;
                    CH_LO_N, CH_UP_N:             bytes[0] = CTL_LF;
                    CH_LO_R, CH_UP_R:             bytes[0] = CTL_CR;
                    CH_LO_T, CH_UP_T:             bytes[0] = CTL_TAB;
                    CH_LO_X, CH_UP_X: begin
                        bytes[0]  = CH_BSLASH;
                        bytes[1]  = in_byte;
                        n         = 3'd2;
                        mode_next = MODE_RAW;
                        raw_next  = 2'd2;
                    end
                    CH_LO_U, CH_UP_U: begin
                        n           = 3'd0;
                        mode_next   = MODE_HEX;
                        needed_next = (in_byte == CH_LO_U) ? 4'd4 : 4'd8;
                        seen_next   = 4'd0;
                        acc_next    = '0;
                        fail        = in_last;
                    end
                    default: fail = 1'b1;
                endcase
            end
            MODE_HEX: begin
                if (!hex_ok) begin
                    fail = 1'b1;
                end else begin
                    acc_next  = acc_sh;
                    seen_next = seen_inc;
                    if (seen_inc >= needed_reg) begin
                        if (acc_sh > CP_MAX) begin
                            fail = 1'b1;
                        end else begin
                            if (acc_sh <= CP_MAX1) begin
                                bytes[0] = {1'b0, cp[6:0]};
                                n        = 3'd1;
                            end else if (acc_sh <= CP_MAX2) begin
                                bytes[0] = LEAD2 | {3'b000, cp[10:6]};
                                bytes[1] = CONT | {2'b00, cp[5:0]};
                                n        = 3'd2;
                            end else if (acc_sh <= CP_MAX3) begin
                                bytes[0] = LEAD3 | {4'h0, cp[15:12]};
                                bytes[1] = CONT | {2'b00, cp[11:6]};
                                bytes[2] = CONT | {2'b00, cp[5:0]};
                                n        = 3'd3;
                            end else begin
                                bytes[0] = LEAD4 | {5'b00000, cp[20:18]};
                                bytes[1] = CONT | {2'b00, cp[17:12]};
                                bytes[2] = CONT | {2'b00, cp[11:6]};
                                bytes[3] = CONT | {2'b00, cp[5:0]};
                                n        = 3'd4;
                            end
                            mode_next   = MODE_PLAIN;
                            needed_next = 4'd0;
                            seen_next   = 4'd0;
                            acc_next    = '0;
                        end
                    end else if (in_last) begin
                        fail = 1'b1;
                    end
                end
            end
            MODE_RAW: begin
                bytes[0] = in_byte;
                n        = 3'd1;
                raw_next = raw_reg - 2'd1;
                if (raw_reg == 2'd1) begin
                    mode_next = MODE_PLAIN;
                end
            end
            MODE_DROP: begin
                // dropped bytes are silent; the closing byte reports the error
                if (in_last) begin
                    n   = 3'd1;
                    err = 1'b1;
                end
            end
            default: begin
                if (in_byte == CH_BSLASH && !in_last) begin
                    mode_next = MODE_ESC;
                end else begin
                    bytes[0] = in_byte;
                    n        = 3'd1;
                end
            end
        endcase

        if (fail) begin
            bytes     = '0;
            n         = 3'd1;
            err       = 1'b1;
            mode_next = MODE_DROP;
        end

        if (in_last) begin
            mode_next   = MODE_PLAIN;
            needed_next = 4'd0;
            seen_next   = 4'd0;
            acc_next    = '0;
            raw_next    = 2'd0;
        end
    end

    assign n_m1          = n - 3'd1;
    assign grp.data      = bytes;
    assign grp.cnt_m1    = n_m1[1:0];
    assign grp.err       = err;
    assign grp.str_end   = in_last;
    assign grp_valid     = (n != 3'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_PLAIN;
            needed_reg <= 4'd0;
            seen_reg   <= 4'd0;
            acc_reg    <= '0;
            raw_reg    <= 2'd0;
        end else if (in_accept) begin
            mode_reg   <= mode_next;
            needed_reg <= needed_next;
            seen_reg   <= seen_next;
            acc_reg    <= acc_next;
            raw_reg    <= raw_next;
        end
    end

endmodule

>>> sv/string_escape_utf8_decoder.sv
// Top level: string literal escape decoder with UTF-8 output and result queue.
// Takes one content byte of a quoted literal per beat (tlast on its final byte) and
// returns the decoded bytes, with \uXXXX and \UXXXXXXXX turned into 1 to 4 UTF-8 bytes.
// Each input beat is decoded in the cycle it is accepted and its results go into a
// two-entry group queue; the output sends one result per cycle unless m_tready stalls
// it. Plain bytes and simple escapes thus run at one input byte per cycle with no gaps
// while the output is not stalled. A byte with N results takes N output beats, so a run
// of UTF-8 bursts limits the input to the output beat rate once both entries are taken.
// A malformed escape yields one error beat, the rest of the literal is dropped, and the
// literal's final byte closes it with an error beat flagged as string end.
`include "string_escape_utf8_decoder_assert.svh"

module string_escape_utf8_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // run_last
    output logic [1:0] m_tuser    // [0] string_end, [1] error
);
    import seud_pkg::*;

    seud_grp_t  dec_grp;
    logic       dec_valid;
    logic       s_accept;
    logic       push;
    logic       pop;
    logic       beat;
    logic       last_beat;

    seud_grp_t  grp_reg [2];
    seud_grp_t  head;
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] idx_reg, idx_next;

    assign s_accept = s_tvalid && s_tready;

    seud_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (s_accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .grp       (dec_grp),
        .grp_valid (dec_valid)
    );

    assign head      = grp_reg[rd_ptr_reg];
    assign s_tready  = (cnt_reg != 2'd2);
    assign m_tvalid  = (cnt_reg != 2'd0);
    assign beat      = m_tvalid && m_tready;
    assign last_beat = (idx_reg == head.cnt_m1);
    assign pop       = beat && last_beat;
    assign push      = s_accept && dec_valid;

    assign m_tdata    = head.data[idx_reg];
    assign m_tlast    = last_beat;
    assign m_tuser[0] = head.str_end && last_beat;
    assign m_tuser[1] = head.err;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
        idx_next = idx_reg;
        if (pop) begin
            idx_next = 2'd0;
        end else if (beat) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
            idx_reg    <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            grp_reg[wr_ptr_reg] <= dec_grp;
        end
    end

    `SEUD_ASSERT(a_cnt_range, cnt_reg != 2'd3, "result queue count out of range")
    `SEUD_ASSERT(a_err_single, m_tvalid && m_tuser[1] |-> m_tlast && m_tdata == 8'h00, "error beat not a lone zero result")
    `SEUD_ASSERT(a_idx_bound, m_tvalid |-> idx_reg <= head.cnt_m1, "result index past group end")
    `SEUD_ASSERT(a_push_count, push && !pop |=> cnt_reg == $past(cnt_reg) + 2'd1, "queue count missed a push")

endmodule

>>> verif/tb.sv
// Testbench for string_escape_utf8_decoder: escape and UTF-8 decode checked against a predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam int RANDOM_ITEMS = 420;
    localparam int DRAIN_CYCLES = 20;

    typedef enum logic [2:0] {
        DEC_PLAIN = 3'd0,
        DEC_ESC   = 3'd1,
        DEC_HEX   = 3'd2,
        DEC_RAW   = 3'd3,
        DEC_DROP  = 3'd4
    } dec_mode_t;

    typedef struct {
        logic [7:0] data;
        bit         run_last;
        bit         str_end;
        bit         err;
    } dec_beat_t;

    class literal_decode_sb;
        dec_mode_t   mode;
        logic [3:0]  need;
        logic [3:0]  seen;
        logic [31:0] acc;
        logic [1:0]  raw_left;
        dec_beat_t   step_q[$];
        dec_beat_t   decoded_q[$];
        int          errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            mode = DEC_PLAIN;
            need = '0;
            seen = '0;
            acc = '0;
            raw_left = '0;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 100)
                $display("tb: mismatch at %0t: %s", $realtime, msg);
        endtask

        function void add(logic [7:0] b, bit e);
            dec_beat_t r;
            if (step_q.size() >= 4)
                return;
            r.data = b;
            r.run_last = 0;
            r.str_end = 0;
            r.err = e;
            step_q.insert(step_q.size(), r);
        endfunction

        function int nibble_of(logic [7:0] c);
            if (c >= "0" && c <= "9") return int'(c - "0");
            if (c >= "a" && c <= "f") return int'(c - "a") + 10;
            if (c >= "A" && c <= "F") return int'(c - "A") + 10;
            return -1;
        endfunction

        function void add_utf8(logic [31:0] cp);
            if (cp <= 32'h7F) begin
                add(cp[7:0], 0);
            end else if (cp <= 32'h7FF) begin
                add({3'b110, cp[10:6]}, 0);
                add({2'b10, cp[5:0]}, 0);
            end else if (cp <= 32'hFFFF) begin
                add({4'b1110, cp[15:12]}, 0);
                add({2'b10, cp[11:6]}, 0);
                add({2'b10, cp[5:0]}, 0);
            end else begin
                add({5'b11110, cp[20:18]}, 0);
                add({2'b10, cp[17:12]}, 0);
                add({2'b10, cp[11:6]}, 0);
                add({2'b10, cp[5:0]}, 0);
            end
        endfunction

        // Work out the results of one accepted input beat.
        function void note_beat(logic [7:0] c, bit last);
            bit fail;
            int d;
            fail = 0;
            step_q.delete();
            case (mode)
                DEC_ESC: begin
                    mode = DEC_PLAIN;
                    case (c)
                        CH_BSL, CH_APOS, CH_QUOTE: add(c, 0);
                        "b", "B": add(8'h08, 0);
                        "f", "F": add(8'h0C, 0);
                        "n", "N": add(8'h0A, 0);
                        "r", "R": add(8'h0D, 0);
                        "t", "T": add(8'h09, 0);
                        "x", "X": begin
                            add(CH_BSL, 0);
                            add(c, 0);
                            mode = DEC_RAW;
                            raw_left = 2'd2;
                        end
                        "u", "U": begin
                            mode = DEC_HEX;
                            need = (c == "u") ? 4'd4 : 4'd8;
                            seen = '0;
                            acc = '0;
                            if (last)
                                fail = 1;
                        end
                        default: fail = 1;
                    endcase
                end
                DEC_HEX: begin
                    d = nibble_of(c);
                    if (d < 0) begin
                        fail = 1;
                    end else begin
                        acc = {acc[27:0], 4'(d)};
                        seen = seen + 4'd1;
                        if (seen >= need) begin
                            if (acc > 32'h10FFFF) begin
                                fail = 1;
                            end else begin
                                add_utf8(acc);
                                clear();
                            end
                        end else if (last) begin
                            fail = 1;
                        end
                    end
                end
                DEC_RAW: begin
                    add(c, 0);
                    raw_left = raw_left - 2'd1;
                    if (raw_left == 2'd0)
                        mode = DEC_PLAIN;
                end
                DEC_DROP: begin
                    if (last)
                        add(8'h00, 1);
                end
                default: begin
                    if (c == CH_BSL && !last)
                        mode = DEC_ESC;
                    else
                        add(c, 0);
                end
            endcase

            if (fail) begin
                step_q.delete();
                add(8'h00, 1);
                mode = DEC_DROP;
            end
            if (step_q.size() > 0) begin
                step_q[step_q.size()-1].run_last = 1;
                if (last)
                    step_q[step_q.size()-1].str_end = 1;
            end
            if (last)
                clear();
            foreach (step_q[i])
                decoded_q.insert(decoded_q.size(), step_q[i]);
        endfunction

        task check_beat(logic [7:0] data, logic tlast, logic [1:0] tuser);
            dec_beat_t e;
            if (decoded_q.size() == 0) begin
                report($sformatf("result with nothing pending: data %h", data));
                return;
            end
            e = decoded_q.pop_front();
            if (tlast !== e.run_last)
                report($sformatf("run_last %b, want %b", tlast, e.run_last));
            if (tuser[0] !== e.str_end)
                report($sformatf("string_end %b, want %b", tuser[0], e.str_end));
            if (tuser[1] !== e.err)
                report($sformatf("error %b, want %b", tuser[1], e.err));
            // out_byte carries no meaning on an error beat
            if (!e.err && data !== e.data)
                report($sformatf("out_byte %h, want %h", data, e.data));
        endtask
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [1:0] m_tuser;

    literal_decode_sb sb = new();
    bit quiet = 0;
    int hold_left = 0;
    int items_sent = 0;

    string_escape_utf8_decoder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #1_000_000;
        $display("tb: FAIL");
        $finish;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Input beats are noted before output beats are checked in the same cycle.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_beat(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                sb.check_beat(m_tdata, m_tlast, m_tuser);
        end
    end

    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            m_tready <= 1'b0;
            hold_left <= pick_gap() - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic l);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= l;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic run_literal(input logic [7:0] lit[$]);
        foreach (lit[i])
            send_beat(lit[i], i == lit.size() - 1);
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] n, bit up);
        if (n < 4'd10)
            return 8'("0") + 8'(n);
        return (up ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [31:0] pick_code(bit wide);
        logic [31:0] edges[7] = '{32'h0, 32'h7F, 32'h80, 32'h7FF, 32'h800, 32'hFFFF, 32'hD800};
        int r;
        r = $urandom_range(0, 9);
        if (!wide)
            return (r < 3) ? edges[$urandom_range(0, 6)] : 32'($urandom_range(0, 16'hFFFF));
        case (r)
            0: return 32'h10FFFF;
            1: return 32'h110000;
            2: return $urandom;
            3: return $urandom_range(0, 1) ? 32'h10000 : 32'hFFFF;
            default: return $urandom_range(0, 32'h10FFFF);
        endcase
    endfunction

    // Builds one random literal: mostly well-formed escapes, some noise and breakage.
    task automatic random_literal(output logic [7:0] lit[$]);
        logic [7:0] simple[13] = '{CH_BSL, CH_APOS, CH_QUOTE, "b", "B", "f", "F",
                                   "n", "N", "r", "R", "t", "T"};
        logic [7:0] junk[8] = '{"g", "z", ":", " ", "/", "@", "G", 8'hFF};
        logic [31:0] cp;
        int segs, r, nd, bad, cut;
        bit wide, stop;
        lit.delete();
        segs = $urandom_range(1, 6);
        stop = 0;
        for (int s = 0; s < segs && !stop; s++) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                repeat ($urandom_range(1, 4)) lit.insert(lit.size(), 8'($urandom_range(0, 255)));
            end else if (r < 45) begin
                lit.insert(lit.size(), CH_BSL);
                lit.insert(lit.size(), simple[$urandom_range(0, 12)]);
            end else if (r < 53) begin
                lit.insert(lit.size(), CH_BSL);
                lit.insert(lit.size(), $urandom_range(0, 1) ? 8'("x") : 8'("X"));
                repeat (2) lit.insert(lit.size(), 8'($urandom_range(0, 255)));
            end else if (r < 92) begin
                wide = (r >= 71 && r < 85) || (r >= 85 && $urandom_range(0, 1));
                nd = wide ? 8 : 4;
                cp = pick_code(wide);
                bad = (r >= 85) ? $urandom_range(0, nd - 1) : -1;
                lit.insert(lit.size(), CH_BSL);
                lit.insert(lit.size(), wide ? 8'("U") : 8'("u"));
                for (int k = nd - 1; k >= 0; k--) begin
                    if (k == bad)
                        lit.insert(lit.size(), junk[$urandom_range(0, 7)]);
                    else
                        lit.insert(lit.size(), hex_char(cp[4*k +: 4], $urandom_range(0, 1)));
                end
            end else if (r < 97) begin
                lit.insert(lit.size(), CH_BSL);
                lit.insert(lit.size(), 8'($urandom_range(0, 255)));
            end else begin
                lit.insert(lit.size(), CH_BSL);
                stop = 1;
            end
        end
        // cut some literals short so escapes end early
        if ($urandom_range(0, 9) == 0 && lit.size() > 1) begin
            cut = $urandom_range(1, lit.size() - 1);
            while (lit.size() > cut) void'(lit.pop_back());
        end
    endtask

    initial begin
        logic [7:0] lit[$];
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // byte extremes, lone trailing backslash, short x escape, missing digits,
        // unknown escape with dropped tail, bad digit, code point out of range
        lit = '{8'h00, 8'hFF};                                  run_literal(lit);
        lit = '{CH_BSL};                                        run_literal(lit);
        lit = '{CH_BSL, "x", "A"};                              run_literal(lit);
        lit = '{CH_BSL, "u", "7", "f"};                         run_literal(lit);
        lit = '{CH_BSL, "q", "a", "b"};                         run_literal(lit);
        lit = '{CH_BSL, "u", "g"};                              run_literal(lit);
        lit = '{CH_BSL, "U", "0", "0", "1", "1", "0", "0", "0", "0"}; run_literal(lit);

        while (items_sent < RANDOM_ITEMS) begin
            random_literal(lit);
            quiet = ($urandom_range(0, 7) == 0);
            run_literal(lit);
        end
        s_tvalid <= 1'b0;
        quiet = 0;

        // let the monitor note the final input beat before waiting on the queue
        @(posedge aclk);
        while (sb.decoded_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule

>>> files.f
+incdir+sv
sv/seud_pkg.sv
sv/seud_decode.sv
sv/string_escape_utf8_decoder.sv
verif/tb.sv
